>>> src/ising_metropolis_spin_update_core_defines.svh
// Assertion macros for the Ising Metropolis spin update core checker.
// No dependencies; included by the checker file only.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_CORE_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ISMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define ISMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ismc_pkg.sv
// Shared types and constants for the Ising Metropolis spin update core.
// No dependencies; used by the controller, datapath, top level and checker.
package ismc_pkg;

   // Lattice side length default
   localparam int SIDE_DEF = 64;

   // Field widths
   localparam int COORD_W   = 6;
   localparam int IN_SPAN   = 1 << COORD_W;
   localparam int DRAW_W    = 16;
   localparam int DRAW_BITS = 16;
   localparam int PROB_W    = 17;
   localparam int DE_W      = 5;
   localparam int MAG_W     = 14;
   localparam int CSR_IDX_W = 8;

   // Effective bits of the random draw
   localparam logic [DRAW_W-1:0] DRAW_MASK = (DRAW_BITS >= DRAW_W) ? {DRAW_W{1'b1}} :
                                             DRAW_W'((1 << DRAW_BITS) - 1);

   // Request tdata layout
   localparam int REQ_TDATA_W = 32;
   localparam int ROW_LSB     = 0;
   localparam int COL_LSB     = ROW_LSB + COORD_W;
   localparam int SPIN_LSB    = COL_LSB + COORD_W;
   localparam int DRAW_LSB    = SPIN_LSB + 1;

   // Response tdata layout
   localparam int RSP_TDATA_W = 24;
   localparam int FLIP_LSB    = 0;
   localparam int DE_LSB      = FLIP_LSB + 1;
   localparam int MAG_LSB     = DE_LSB + DE_W;
   localparam int RSP_USED_W  = MAG_LSB + MAG_W;

   // Item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_TRIAL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_UP4 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_UP8 = CSR_IDX_W'(1);

   // Energy change codes seen on the result
   localparam logic [DE_W-1:0] DE_NEG8 = 5'b11000;
   localparam logic [DE_W-1:0] DE_NEG4 = 5'b11100;
   localparam logic [DE_W-1:0] DE_ZERO = 5'b00000;
   localparam logic [DE_W-1:0] DE_POS4 = 5'b00100;
   localparam logic [DE_W-1:0] DE_POS8 = 5'b01000;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_NEAR,
      ST_READ_FAR,
      ST_EVAL,
      ST_COMMIT
   } ismc_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_wr;     // write one all-up row during the clearing pass
      logic take;       // capture the accepted request
      logic rd_near;    // read rows r and r+1 (else row r-1)
      logic hold_near;  // latch rows r and r+1
      logic eval;       // compute energy change and flip decision
      logic commit;     // write row, update sum, load result
   } ismc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;   // clearing pass is on its last row
      logic slot_free;  // result register can take a new transaction
   } ismc_sts_type;

endpackage

>>> src/ising_metropolis_spin_update_core.sv
// Ising Metropolis spin update core. Holds a SIDE x SIDE periodic lattice of
// up/down spins in a row-wide memory with two read ports, plus a running spin sum.
// A load transaction writes one spin; a trial transaction computes the energy
// change of flipping the addressed spin from its four wrapped neighbors and flips
// it when the change is zero or negative, or when the random draw is below the
// acceptance register for +4 or +8. Every request returns one response with the
// flip flag, energy change and magnetization. After acceptance a request passes
// through READ_NEAR and READ_FAR, which fetch three lattice rows through the two
// read ports, then EVAL, which evaluates, and COMMIT, which writes back and loads
// the response into the output register. The write-back waits while an earlier
// response is still unread. The next request is accepted in the cycle after the
// write-back, so no new request is taken while one is in flight. After reset a
// clearing pass over all SIDE rows sets all spins up; no request is accepted during
// it, while configuration writes are taken at any time.
module ising_metropolis_spin_update_core import ismc_pkg::*; #(
   parameter int SIDE = SIDE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // row[5:0], col[11:6], spin_up[12],
                                              // uniform_draw[28:13], zero pad
   input  logic                   req_tuser,  // kind: 0 load, 1 trial
   // Response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // flipped[0], energy_change[5:1],
                                              // magnetization[19:6], zero pad
   // Register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [PROB_W-1:0]      csr_data
);

   ismc_cmd_type cmd;
   ismc_sts_type sts;

   // Registers are always writable
   assign csr_ready = 1'b1;

   ismc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ismc_datapath #(
      .SIDE (SIDE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

>>> src/ismc_ctrl.sv
// Sequencer for the Ising Metropolis spin update core.
// Depends on ismc_pkg for the state, command and status types.
module ismc_ctrl import ismc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ismc_sts_type sts,
   output ismc_cmd_type cmd
);

   ismc_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ_NEAR;
         end
         ST_READ_NEAR: state_in = ST_READ_FAR;
         ST_READ_FAR:  state_in = ST_EVAL;
         ST_EVAL:      state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (sts.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_READ_NEAR: cmd.rd_near   = 1'b1;
         ST_READ_FAR:  cmd.hold_near = 1'b1;
         ST_EVAL:      cmd.eval      = 1'b1;
         ST_COMMIT:    cmd.commit    = sts.slot_free;
         default: ;
      endcase
   end

endmodule

>>> src/ismc_datapath.sv
// Datapath of the Ising Metropolis spin update core: row memory, neighbor
// evaluation, acceptance registers, spin sum and result register. Uses ismc_pkg.
module ismc_datapath import ismc_pkg::*; #(
   parameter int SIDE = SIDE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ismc_cmd_type           cmd,
   output ismc_sts_type           sts,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [PROB_W-1:0]      csr_data
);

   localparam int IDX_W = $clog2(SIDE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);

   // Coordinate reduction table: value mod SIDE
   logic [IDX_W-1:0] mod_tab [IN_SPAN];
   for (genvar gi = 0; gi < IN_SPAN; gi++) begin : g_mod
      assign mod_tab[gi] = IDX_W'(gi % SIDE);
   end

   // Acceptance registers
   logic [PROB_W-1:0] prob4_ff, prob8_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         prob4_ff <= '0;
         prob8_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEPT_UP4: prob4_ff <= csr_data;
            CSR_ACCEPT_UP8: prob8_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Captured request
   logic              kind_ff, up_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic [IDX_W-1:0]  r_ff, c_ff;
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff <= req_tuser;
         up_ff   <= req_tdata[SPIN_LSB];
         draw_ff <= req_tdata[DRAW_LSB +: DRAW_W] & DRAW_MASK;
         r_ff    <= mod_tab[req_tdata[ROW_LSB +: COORD_W]];
         c_ff    <= mod_tab[req_tdata[COL_LSB +: COORD_W]];
      end
   end

   // Wrapped neighbor indexes
   logic [IDX_W-1:0] rn, rp, cn, cp;
   assign rn = (r_ff == LAST_IDX) ? '0 : r_ff + IDX_W'(1);
   assign rp = (r_ff == '0) ? LAST_IDX : r_ff - IDX_W'(1);
   assign cn = (c_ff == LAST_IDX) ? '0 : c_ff + IDX_W'(1);
   assign cp = (c_ff == '0) ? LAST_IDX : c_ff - IDX_W'(1);

   // Clearing pass counter
   logic [IDX_W-1:0] clr_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
      end
   end

   // Row memory, one lattice row per word, 1 = spin up
   logic [SIDE-1:0] mem [SIDE];
   logic [SIDE-1:0] rd_a_ff, rd_b_ff, new_row_ff;
   logic [IDX_W-1:0] addr_a;
   assign addr_a = cmd.rd_near ? r_ff : rp;

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_cnt_ff] <= '1;
      end else if (cmd.commit) begin
         mem[r_ff] <= new_row_ff;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[rn];
   end

   // Hold the site row and the row below
   logic [SIDE-1:0] row_s_ff, row_n_ff;
   always_ff @(posedge clock) begin
      if (cmd.hold_near) begin
         row_s_ff <= rd_a_ff;
         row_n_ff <= rd_b_ff;
      end
   end

   // Energy change: 4 * (neighbors aligned with the site) - 8
   logic            ob, nb, accept;
   logic [2:0]      eq;
   logic [DE_W-1:0] de_calc;
   logic [SIDE-1:0] new_row;
   always_comb begin
      ob = row_s_ff[c_ff];
      eq = {2'b00, ~(row_n_ff[c_ff] ^ ob)} + {2'b00, ~(rd_a_ff[c_ff] ^ ob)}
         + {2'b00, ~(row_s_ff[cn] ^ ob)} + {2'b00, ~(row_s_ff[cp] ^ ob)};
      de_calc = DE_W'({eq, 2'b00}) - DE_W'(8);
      case (eq)
         3'd3:    accept = {1'b0, draw_ff} < prob4_ff;
         3'd4:    accept = {1'b0, draw_ff} < prob8_ff;
         default: accept = 1'b1;
      endcase
      nb = (kind_ff == KIND_TRIAL) ? (ob ^ accept) : up_ff;
      new_row = row_s_ff;
      new_row[c_ff] = nb;
   end

   logic            flip_ff, chg_ff, nb_ff;
   logic [DE_W-1:0] de_ff;
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         new_row_ff <= new_row;
         flip_ff    <= (kind_ff == KIND_TRIAL) && accept;
         de_ff      <= (kind_ff == KIND_TRIAL) ? de_calc : DE_ZERO;
         chg_ff     <= nb ^ ob;
         nb_ff      <= nb;
      end
   end

   // Running spin sum, kept modulo 2^MAG_W
   logic [MAG_W-1:0] total_ff, total_in;
   always_comb begin
      total_in = total_ff;
      if (chg_ff) total_in = nb_ff ? total_ff + MAG_W'(2) : total_ff - MAG_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= MAG_W'(SIDE * SIDE);
      end else if (cmd.commit) begin
         total_ff <= total_in;
      end
   end

   // Result register
   logic             rsp_valid_ff, rsp_flip_ff;
   logic [DE_W-1:0]  rsp_de_ff;
   logic [MAG_W-1:0] rsp_mag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_flip_ff <= flip_ff;
         rsp_de_ff   <= de_ff;
         rsp_mag_ff  <= total_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_USED_W){1'b0}}, rsp_mag_ff, rsp_de_ff, rsp_flip_ff};

   // Status
   assign sts.clr_last  = (clr_cnt_ff == LAST_IDX);
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

endmodule

>>> src/ismc_checker.sv
// Port-level checker for the Ising Metropolis spin update core, bound to the top.
// Depends on ismc_pkg and ising_metropolis_spin_update_core_defines.svh.
`include "ising_metropolis_spin_update_core_defines.svh"

module ismc_checker import ismc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [DE_W-1:0] de_seen;
   logic            stalled, de_legal, downhill, flip_seen;
   assign de_seen   = rsp_tdata[DE_LSB +: DE_W];
   assign stalled   = rsp_tvalid && !rsp_tready;
   assign de_legal  = de_seen == DE_NEG8 || de_seen == DE_NEG4 || de_seen == DE_ZERO ||
                      de_seen == DE_POS4 || de_seen == DE_POS8;
   assign downhill  = rsp_tvalid && de_seen[DE_W-1];
   assign flip_seen = rsp_tdata[FLIP_LSB];

   // A stalled response stays valid
   `ISMC_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid, "response dropped")

   // A stalled response keeps its payload
   `ISMC_ASSERT_NEXT(a_rsp_stable, clock, reset, stalled, $stable(rsp_tdata), "payload changed")

   // Energy change is one of the five lattice values
   `ISMC_ASSERT_NOW(a_de_legal, clock, reset, rsp_tvalid, de_legal, "illegal energy change")

   // Downhill moves always flip
   `ISMC_ASSERT_NOW(a_downhill_flips, clock, reset, downhill, flip_seen, "downhill not flipped")

   // Ready is low just after reset is released, while the lattice is being cleared
   `ISMC_ASSERT_NOW(a_clear_blocks, clock, reset, $past(reset), !req_tready, "ready while clearing")

endmodule

bind ising_metropolis_spin_update_core ismc_checker u_ismc_checker (.*);
